FILE: rtl/smoothing_3x3_filter_defines.svh
// Assertion macros for the 3x3 smoothing filter.
// Used by the RTL files that carry assertions; no other dependencies.
`ifndef SMOOTHING_3X3_FILTER_DEFINES_SVH
`define SMOOTHING_3X3_FILTER_DEFINES_SVH

// property holds at every rising clock edge outside reset
`define SSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition never occurs outside reset
`define SSF_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

FILE: rtl/ssf_pkg.sv
// Shared constants, types and arithmetic helpers for the 3x3 smoothing filter.
// No dependencies; used by smoothing_3x3_filter.
`default_nettype none

package ssf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = COL_W + 1;
    localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W   = OUT_ROW_W + 1;
    localparam int IN_ROW_W   = OUT_ROW_W + 1;
    localparam int CFG_DATA_W = HEIGHT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 24;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int SUM_W      = 12;
    localparam int TAPS       = 9;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // x / 10 == (x * 3277) >> 15 for every x below 2^13
    localparam int DIV10_MUL   = 3277;
    localparam int DIV10_SHIFT = 15;
    localparam int PROD_W      = 2 * SUM_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
    } border_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             ge1;
        logic             ge2;
        logic             emit;
        logic             last;
        border_t          border;
    } s1_ctl_t;

    function automatic logic [SUM_W-1:0] win_sum(
        input logic [TAPS-1:0][7:0] taps,
        input border_t              border
    );
        logic [SUM_W-1:0] acc;
        logic             col_ok;
        logic             row_ok;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                col_ok = (k == 0) ? border.left_ok : ((k == 2) ? border.right_ok : 1'b1);
                row_ok = (t == 0) ? border.top_ok  : ((t == 2) ? border.bot_ok   : 1'b1);
                if (col_ok && row_ok) begin
                    if (k == 1 && t == 1) begin
                        acc = acc + SUM_W'({taps[k*3+t], 1'b0});
                    end else begin
                        acc = acc + SUM_W'(taps[k*3+t]);
                    end
                end
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] div10_clamp(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        prod = PROD_W'(x) * PROD_W'(DIV10_MUL);
        quo  = prod >> DIV10_SHIFT;
        if (quo > PROD_W'(255)) begin
            return 8'hFF;
        end
        return quo[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ssf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ssf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/smoothing_3x3_filter.sv
// Top level of the 3x3 smoothing filter: position counters, line buffer, window and output.
// Depends on ssf_pkg, ssf_ram and smoothing_3x3_filter_defines.svh.
//
// Takes one RGB pixel per clock in raster order while the output is not stalled; an output stall
// holds the input back. Each pixel passes three register stages: position logic and the
// line-buffer read, window shift with the nine-tap sum, then divide by ten into the output
// register. The line buffer is one 2048 x 48 RAM holding the two rows above, read and written
// once per item. A result leaves one row plus one pixel behind its input, so a frame needs
// width*height + width + 1 input items; tuser marks padding items used for the flush.
// A configuration write restarts the frame; the user makes it only while idle (not enforced).
`default_nettype none

module smoothing_3x3_filter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [23:0]                      s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  wire logic [0:0]                       s_tuser,   // padding
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [23:0]                      m_tdata,   // out_red, out_green, out_blue
    output      logic                             m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [ssf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W     = ssf_pkg::COL_W;
    localparam int WIDTH_W   = ssf_pkg::WIDTH_W;
    localparam int HEIGHT_W  = ssf_pkg::HEIGHT_W;
    localparam int IN_ROW_W  = ssf_pkg::IN_ROW_W;
    localparam int OUT_ROW_W = ssf_pkg::OUT_ROW_W;
    localparam int SUM_W     = ssf_pkg::SUM_W;
    localparam int LINE_W    = ssf_pkg::LINE_W;
    localparam int PIX_W     = ssf_pkg::PIX_W;
    localparam int TAPS      = ssf_pkg::TAPS;

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;

    // input position and output position
    logic [COL_W-1:0]     in_col_reg,  in_col_next;
    logic [IN_ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    // stage 1
    logic                s1_valid_reg;
    ssf_pkg::s1_ctl_t    s1_ctl_reg,  s1_ctl_next;
    ssf_pkg::rgb_t       s1_pix_reg,  s1_pix_next;
    logic                s1_fwd_reg;
    logic [LINE_W-1:0]   s1_fwd_data_reg;
    logic                s1_adv;

    // stage 2
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_red_reg, s2_green_reg, s2_blue_reg;
    logic                s2_last_reg;
    logic                s2_adv;

    // output
    logic                m_valid_reg;
    logic [23:0]         m_data_reg;
    logic                m_last_reg;

    logic                in_acc;
    logic                row_ge1, row_ge2, emit0, last0;
    logic [WIDTH_W-1:0]  in_col_inc, out_col_inc;
    logic [HEIGHT_W-1:0] out_row_inc;

    logic [LINE_W-1:0]   ram_rdata, line_raw, ram_wdata;
    ssf_pkg::rgb_t       above, above2;
    ssf_pkg::rgb_t       win_reg   [TAPS];
    ssf_pkg::rgb_t       win_shift [TAPS];
    logic [TAPS-1:0][7:0] red_taps, green_taps, blue_taps;

    // ---------------- configuration ----------------
    always_comb begin
        cfg_width = cfg_data[WIDTH_W-1:0];
        if (cfg_width == '0) begin
            cfg_width = WIDTH_W'(1);
        end else if (cfg_width > ssf_pkg::WIDTH_MAX) begin
            cfg_width = ssf_pkg::WIDTH_MAX;
        end
        cfg_height = cfg_data[HEIGHT_W-1:0];
        if (cfg_height == '0) begin
            cfg_height = HEIGHT_W'(1);
        end else if (cfg_height > ssf_pkg::HEIGHT_MAX) begin
            cfg_height = ssf_pkg::HEIGHT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ssf_pkg::WIDTH_RESET;
            height_reg <= ssf_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ssf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_width;
                ssf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_height;
            endcase
        end
    end

    // ---------------- stage 0: positions and line read ----------------
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;

    assign row_ge1     = in_row_reg != '0;
    assign row_ge2     = in_row_reg >= IN_ROW_W'(2);
    assign emit0       = row_ge2 || (row_ge1 && in_col_reg != '0);
    assign in_col_inc  = WIDTH_W'(in_col_reg) + WIDTH_W'(1);
    assign out_col_inc = WIDTH_W'(out_col_reg) + WIDTH_W'(1);
    assign out_row_inc = HEIGHT_W'(out_row_reg) + HEIGHT_W'(1);
    assign last0       = emit0 && out_row_inc >= height_reg && out_col_inc >= width_reg;

    always_comb begin
        s1_pix_next = '0;
        if (HEIGHT_W'(in_row_reg) < height_reg && !s_tuser[0]) begin
            s1_pix_next.red   = s_tdata[7:0];
            s1_pix_next.green = s_tdata[15:8];
            s1_pix_next.blue  = s_tdata[23:16];
        end
        s1_ctl_next.col             = in_col_reg;
        s1_ctl_next.ge1             = row_ge1;
        s1_ctl_next.ge2             = row_ge2;
        s1_ctl_next.emit            = emit0;
        s1_ctl_next.last            = last0;
        s1_ctl_next.border.left_ok  = out_col_reg != '0;
        s1_ctl_next.border.right_ok = out_col_inc < width_reg;
        s1_ctl_next.border.top_ok   = out_row_reg != '0;
        s1_ctl_next.border.bot_ok   = out_row_inc < height_reg;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_acc) begin
            if (last0) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (in_col_inc >= width_reg) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + IN_ROW_W'(1);
                end else begin
                    in_col_next = in_col_inc[COL_W-1:0];
                end
                if (emit0) begin
                    if (out_col_inc >= width_reg) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + OUT_ROW_W'(1);
                    end else begin
                        out_col_next = out_col_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- line buffer ----------------
    ssf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (ssf_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_ctl_reg.col),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1: window and sums ----------------
    assign s1_adv = s1_valid_reg && (!s1_ctl_reg.emit || !s2_valid_reg || s2_adv);

    assign line_raw  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign above     = s1_ctl_reg.ge1 ? line_raw[PIX_W-1:0] : '0;
    assign above2    = s1_ctl_reg.ge2 ? line_raw[LINE_W-1:PIX_W] : '0;
    assign ram_wdata = {above, s1_pix_reg};

    always_comb begin
        for (int k = 0; k < TAPS - 3; k++) begin
            win_shift[k] = win_reg[k+3];
        end
        win_shift[TAPS-3] = above2;
        win_shift[TAPS-2] = above;
        win_shift[TAPS-1] = s1_pix_reg;
        for (int k = 0; k < TAPS; k++) begin
            red_taps[k]   = win_shift[k].red;
            green_taps[k] = win_shift[k].green;
            blue_taps[k]  = win_shift[k].blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else if (in_acc) begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= s1_adv && (s1_ctl_reg.col == in_col_reg);
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_ctl_reg      <= s1_ctl_next;
            s1_pix_reg      <= s1_pix_next;
            s1_fwd_data_reg <= ram_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            for (int k = 0; k < TAPS; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_adv) begin
            for (int k = 0; k < TAPS; k++) begin
                win_reg[k] <= s1_ctl_reg.last ? '0 : win_shift[k];
            end
        end
    end

    // ---------------- stage 2: divide and clamp ----------------
    assign s2_adv = s2_valid_reg && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_adv && s1_ctl_reg.emit) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_adv) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_ctl_reg.emit) begin
            s2_red_reg   <= ssf_pkg::win_sum(red_taps,   s1_ctl_reg.border);
            s2_green_reg <= ssf_pkg::win_sum(green_taps, s1_ctl_reg.border);
            s2_blue_reg  <= ssf_pkg::win_sum(blue_taps,  s1_ctl_reg.border);
            s2_last_reg  <= s1_ctl_reg.last;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_data_reg <= {ssf_pkg::div10_clamp(s2_blue_reg),
                           ssf_pkg::div10_clamp(s2_green_reg),
                           ssf_pkg::div10_clamp(s2_red_reg)};
            m_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
`include "smoothing_3x3_filter_defines.svh"

    `SSF_ASSERT(a_s1_hold_only_on_s2_stall, (s1_valid_reg && !s1_adv) |-> (s2_valid_reg && !s2_adv), "stage 1 held without a stage 2 stall")
    `SSF_ASSERT(a_last_restarts_frame, (in_acc && last0) |=> (in_col_reg == '0 && in_row_reg == '0), "frame did not restart after last pixel")
    `SSF_NEVER(a_in_col_range, WIDTH_W'(in_col_reg) >= width_reg, "input column beyond row width")
    `SSF_NEVER(a_out_row_range, HEIGHT_W'(out_row_reg) >= height_reg, "output row beyond frame height")

endmodule

`default_nettype wire
